[design/cpd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared types and codes for the camera packet deframer.
// ----------------------------------------------------------------------------
package cpd_pkg;

  // input kinds
  localparam logic [1:0] KIND_BYTE     = 2'd0;
  localparam logic [1:0] KIND_EXPOSURE = 2'd1;
  localparam logic [1:0] KIND_RESTART  = 2'd2;

  // result events
  localparam logic [1:0] EV_BYTE    = 2'd0;
  localparam logic [1:0] EV_ERROR   = 2'd1;
  localparam logic [1:0] EV_DISCARD = 2'd2;

  // packet types on the output
  localparam logic [1:0] PT_START  = 2'd0;
  localparam logic [1:0] PT_MIDDLE = 2'd1;
  localparam logic [1:0] PT_END    = 2'd2;

  // frame markers from header byte 0
  localparam logic [1:0] MK_MIDDLE  = 2'd0;
  localparam logic [1:0] MK_END     = 2'd1;
  localparam logic [1:0] MK_START   = 2'd2;
  localparam logic [1:0] MK_INVALID = 2'd3;

  // exposure tracking
  localparam logic [1:0] EXP_NONE      = 2'd0;
  localparam logic [1:0] EXP_CHANGED   = 2'd1;
  localparam logic [1:0] EXP_DROP_NEXT = 2'd2;

  localparam int          HDR_BYTES   = 4;
  localparam int          PLEN_W      = 14;  // ((0xffff + 47) >> 4) << 1 fits
  localparam int          TALLY_W     = 24;
  localparam int          PIX_W       = 14;
  localparam logic [TALLY_W-1:0] TALLY_MAX = '1;
  localparam logic [5:0]  PIX_HI_MASK = 6'h3f;
  localparam logic [16:0] LEN_ROUND   = 17'd47;
  localparam int          QUEUE_DEPTH = 4;     // power of two

  // one unit of output work: a single result or a four byte header burst
  typedef struct packed {
    logic [1:0]           ev;
    logic [3:0][7:0]      bytes;
    logic [1:0]           ptype;
    logic                 four;
    logic                 eop;
    logic                 drop;
  } job_t;

  function automatic logic [1:0] type_of(input logic [1:0] marker);
    logic [1:0] t;
    begin
      if (marker == MK_START)       t = PT_START;
      else if (marker == MK_MIDDLE) t = PT_MIDDLE;
      else                          t = PT_END;
      return t;
    end
  endfunction

endpackage

[design/camera_packet_deframer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_packet_deframer_top
// Cuts a compressed camera byte stream into tagged packet bytes.
// ----------------------------------------------------------------------------
// Takes one stream byte or event per clock and is ready whenever the
// four-entry job queue has room. Every byte or event is classified
// combinationally, and whatever owes results is posted as one job; the result
// side drains one result per cycle while the output is ready, so ordinary
// bytes flow at one per clock and pass through the job queue into the output
// register. A completed header comes out as four results in a row, and the
// queue absorbs that burst; in_ready only drops once four jobs are waiting
// behind a stalled or busy output.
// ----------------------------------------------------------------------------
module camera_packet_deframer_top import cpd_pkg::*; #(
  parameter int MAX_PACKET_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_data_byte,
  input  logic        in_transfer_start,
  input  logic        in_transfer_full,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_event_res,
  output logic [7:0]  out_out_byte,
  output logic [1:0]  out_packet_type,
  output logic        out_end_of_packet,
  output logic        out_drop_frame,
  output logic        out_last_of_run
);

  logic q_full, q_push, q_pop, q_head_valid;
  job_t q_job, q_head_job;

  cpd_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_data_byte      (in_data_byte),
    .in_transfer_start (in_transfer_start),
    .in_transfer_full  (in_transfer_full),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_job             (q_job)
  );

  cpd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head_job)
  );

  cpd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (q_head_valid),
    .head_job          (q_head_job),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_res     (out_event_res),
    .out_out_byte      (out_out_byte),
    .out_packet_type   (out_packet_type),
    .out_end_of_packet (out_end_of_packet),
    .out_drop_frame    (out_drop_frame),
    .out_last_of_run   (out_last_of_run)
  );

endmodule

[design/cpd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_front
// Parses the byte stream, tracks packet/frame state and posts output jobs.
// ----------------------------------------------------------------------------
module cpd_front import cpd_pkg::*; #(
  parameter int MAX_PACKET_BYTES = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [1:0]   in_kind,
  input  logic [7:0]   in_data_byte,
  input  logic         in_transfer_start,
  input  logic         in_transfer_full,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [23:0]  cfg_data,
  input  logic         q_full,
  output logic         q_push,
  output job_t         q_job
);

  localparam int LEN_W = $clog2(MAX_PACKET_BYTES + 1);

  logic [LEN_W-1:0]   bip_r, bip_nxt;
  logic [LEN_W-1:0]   plen_r, plen_nxt;
  logic [1:0]         marker_r, marker_nxt;
  logic [TALLY_W-1:0] tally_r, tally_nxt;
  logic               restart_r, restart_nxt;
  logic [1:0]         exp_r, exp_nxt;
  logic               lwfe_r, lwfe_nxt;
  logic               disc_r, disc_nxt;
  logic [TALLY_W-1:0] fpc_r;
  logic [7:0]         hdr_r [0:2];

  logic               acc;
  logic               hdr_we;
  logic [LEN_W-1:0]   bip_inc;
  logic [16:0]        len_sum;
  logic [PLEN_W-1:0]  plen_calc;
  logic [1:0]         hdr_marker;
  logic [PIX_W-1:0]   pixels;
  logic [TALLY_W:0]   tally_sum;
  logic [TALLY_W-1:0] tally_sat;
  logic               disc_v;
  logic               took;
  logic               fin;
  logic               fin_four;
  logic [1:0]         fin_m;
  logic               err;

  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;
  assign acc       = in_valid && in_ready;

  assign bip_inc    = bip_r + LEN_W'(1);
  assign len_sum    = {1'b0, hdr_r[2], in_data_byte} + LEN_ROUND;
  assign plen_calc  = {len_sum[16:4], 1'b0};
  assign hdr_marker = hdr_r[0][7:6];
  assign pixels     = {hdr_r[0][5:0] & PIX_HI_MASK, hdr_r[1]};
  assign tally_sum  = {1'b0, tally_r} + (TALLY_W+1)'(pixels);
  assign tally_sat  = tally_sum[TALLY_W] ? TALLY_MAX : tally_sum[TALLY_W-1:0];

  always_comb begin
    bip_nxt     = bip_r;
    plen_nxt    = plen_r;
    marker_nxt  = marker_r;
    tally_nxt   = tally_r;
    restart_nxt = restart_r;
    exp_nxt     = exp_r;
    lwfe_nxt    = lwfe_r;
    disc_nxt    = disc_r;
    hdr_we      = 1'b0;
    q_push      = 1'b0;
    q_job       = '0;
    disc_v      = disc_r;
    took        = 1'b0;
    fin         = 1'b0;
    fin_four    = 1'b0;
    fin_m       = marker_r;
    err         = 1'b0;

    if (acc) begin
      case (in_kind)
        KIND_EXPOSURE: exp_nxt = EXP_CHANGED;
        KIND_RESTART: begin
          restart_nxt = 1'b0;
          bip_nxt     = '0;
          tally_nxt   = '0;
          exp_nxt     = EXP_NONE;
        end
        KIND_BYTE: begin
          if (!restart_r) begin
            if (in_transfer_start) begin
              disc_v = 1'b0;
              // full transfer right after a frame end or an error is dropped whole
              if (lwfe_r && in_transfer_full) begin
                disc_v   = 1'b1;
                lwfe_nxt = 1'b0;
                took     = 1'b1;
                q_push   = 1'b1;
                q_job.ev = EV_DISCARD;
              end
            end
            disc_nxt = disc_v;
            if (!took && !disc_v) begin
              if (bip_r < LEN_W'(HDR_BYTES - 1)) begin
                hdr_we  = 1'b1;
                bip_nxt = bip_inc;
              end else if (bip_r == LEN_W'(HDR_BYTES - 1)) begin
                bip_nxt = bip_inc;
                if (plen_calc > PLEN_W'(MAX_PACKET_BYTES) || hdr_marker == MK_INVALID) begin
                  err = 1'b1;
                end else begin
                  plen_nxt   = plen_calc[LEN_W-1:0];
                  marker_nxt = hdr_marker;
                  if (plen_calc <= PLEN_W'(HDR_BYTES)) begin
                    fin      = 1'b1;
                    fin_four = 1'b1;
                    fin_m    = hdr_marker;
                  end else begin
                    q_push         = 1'b1;
                    q_job.ev       = EV_BYTE;
                    q_job.bytes[0] = hdr_r[0];
                    q_job.bytes[1] = hdr_r[1];
                    q_job.bytes[2] = hdr_r[2];
                    q_job.bytes[3] = in_data_byte;
                    q_job.ptype    = type_of(hdr_marker);
                    q_job.four     = 1'b1;
                  end
                end
              end else begin
                bip_nxt = bip_inc;
                if (bip_inc >= plen_r) begin
                  fin = 1'b1;
                end else begin
                  q_push         = 1'b1;
                  q_job.ev       = EV_BYTE;
                  q_job.bytes[0] = in_data_byte;
                  q_job.ptype    = type_of(marker_r);
                end
              end
            end
          end
        end
        default: ;
      endcase
    end

    // packet completion
    if (fin) begin
      bip_nxt     = '0;
      q_push      = 1'b1;
      q_job.ev    = EV_BYTE;
      q_job.ptype = type_of(fin_m);
      q_job.four  = fin_four;
      q_job.eop   = 1'b1;
      if (fin_four) begin
        q_job.bytes[0] = hdr_r[0];
        q_job.bytes[1] = hdr_r[1];
        q_job.bytes[2] = hdr_r[2];
        q_job.bytes[3] = in_data_byte;
      end else begin
        q_job.bytes[0] = in_data_byte;
      end
      if (fin_m == MK_END) begin
        tally_nxt = tally_sat;
        if (tally_sat != fpc_r) begin
          err = 1'b1;
        end else begin
          if (exp_r == EXP_CHANGED) begin
            exp_nxt = EXP_DROP_NEXT;
          end else if (exp_r == EXP_DROP_NEXT) begin
            exp_nxt    = EXP_NONE;
            q_job.drop = 1'b1;
          end
          lwfe_nxt = 1'b1;
          disc_nxt = 1'b1;
        end
      end else begin
        tally_nxt = (fin_m == MK_START) ? TALLY_W'(pixels) : tally_sat;
        lwfe_nxt  = 1'b0;
      end
    end

    // error replaces whatever the packet still owed
    if (err) begin
      restart_nxt = 1'b1;
      lwfe_nxt    = 1'b1;
      q_push      = 1'b1;
      q_job       = '0;
      q_job.ev    = EV_ERROR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bip_r     <= '0;
      plen_r    <= '0;
      marker_r  <= MK_MIDDLE;
      tally_r   <= '0;
      restart_r <= 1'b0;
      exp_r     <= EXP_NONE;
      lwfe_r    <= 1'b0;
      disc_r    <= 1'b0;
      fpc_r     <= '0;
    end else begin
      bip_r     <= bip_nxt;
      plen_r    <= plen_nxt;
      marker_r  <= marker_nxt;
      tally_r   <= tally_nxt;
      restart_r <= restart_nxt;
      exp_r     <= exp_nxt;
      lwfe_r    <= lwfe_nxt;
      disc_r    <= disc_nxt;
      if (cfg_valid && cfg_ready) begin
        fpc_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr_r[bip_r[1:0]] <= in_data_byte;
    end
  end

endmodule

[design/cpd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_queue
// Small job FIFO between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module cpd_queue import cpd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  job_t  push_job,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output job_t  head_job
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem_r [0:QUEUE_DEPTH-1];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full       = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop)      cnt_nxt = cnt_r + CNT_W'(1);
    else if (!do_push && do_pop) cnt_nxt = cnt_r - CNT_W'(1);
  end

  // pointers wrap on their own width since the depth is a power of two
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[design/cpd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_back
// Expands queued jobs into result requests behind an output register.
// ----------------------------------------------------------------------------
module cpd_back import cpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  job_t        head_job,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_event_res,
  output logic [7:0]  out_out_byte,
  output logic [1:0]  out_packet_type,
  output logic        out_end_of_packet,
  output logic        out_drop_frame,
  output logic        out_last_of_run
);

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] ev_r;
  logic [7:0] byte_r;
  logic [1:0] ptype_r;
  logic       eop_r, drop_r, last_r;
  logic       load;
  logic       last;

  assign load = (!out_valid_r || out_ready) && head_valid;
  assign last = !head_job.four || (idx_r == 2'd3);
  assign pop  = load && last;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ev_r    <= head_job.ev;
      byte_r  <= head_job.bytes[idx_r];
      ptype_r <= head_job.ptype;
      eop_r   <= last && head_job.eop;
      drop_r  <= last && head_job.drop;
      last_r  <= last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_res     = ev_r;
  assign out_out_byte      = byte_r;
  assign out_packet_type   = ptype_r;
  assign out_end_of_packet = eop_r;
  assign out_drop_frame    = drop_r;
  assign out_last_of_run   = last_r;

endmodule

[design/cpd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_checker
// Port-level checks for the camera packet deframer.
// ----------------------------------------------------------------------------
module cpd_checker import cpd_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_event_res,
  input logic [7:0] out_out_byte,
  input logic [1:0] out_packet_type,
  input logic       out_end_of_packet,
  input logic       out_drop_frame,
  input logic       out_last_of_run
);

  // stalled request holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_res) &&
    $stable(out_out_byte) && $stable(out_last_of_run))
    else $error("output request changed while stalled");

  // errors and discards are lone results with no packet tags
  a_event_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res != EV_BYTE |->
    out_last_of_run && !out_end_of_packet && !out_drop_frame)
    else $error("event result not standalone");

  a_drop_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drop_frame |-> out_end_of_packet && out_packet_type == PT_END)
    else $error("drop flag outside frame end byte");

  a_eop_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_packet |-> out_last_of_run)
    else $error("end of packet not on last result of its input");

endmodule

bind camera_packet_deframer_top cpd_checker u_cpd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_event_res     (out_event_res),
  .out_out_byte      (out_out_byte),
  .out_packet_type   (out_packet_type),
  .out_end_of_packet (out_end_of_packet),
  .out_drop_frame    (out_drop_frame),
  .out_last_of_run   (out_last_of_run)
);
